FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, skipped while reset is high
`define PTH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define PTH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pth_pkg.sv
// shared constants and types of the temporal high-pass filter
package pth_pkg;

   // frame store geometry
   localparam int MAX_PIXELS  = 1024;
   localparam int ADDR_BITS   = $clog2(MAX_PIXELS);
   localparam int FILL_BITS   = $clog2(MAX_PIXELS + 1);
   localparam int STORE_BITS  = 16;
   localparam int FRAC_BITS   = 4;

   // payload widths
   localparam int PIXEL_BITS  = 12;
   localparam int HP_BITS     = 13;

   // configuration registers
   localparam int FRAME_BITS      = 11;
   localparam int SHIFT_BITS      = 4;
   localparam int CSR_DATA_BITS   = 11;
   localparam int CSR_INDEX_BITS  = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_PIXELS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHIFT_AMOUNT = 2'd1;
   localparam logic [FRAME_BITS-1:0] FRAME_PIXELS_RESET = 11'd1024;
   localparam logic [SHIFT_BITS-1:0] SHIFT_AMOUNT_RESET = 4'd4;

   // output queue
   localparam int QUEUE_DEPTH = 3;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_BITS    = QCNT_BITS + 1;

   // one result transaction
   typedef struct packed {
      logic signed [HP_BITS-1:0] highpass;
      logic                      frame_end;
   } rsp_item_type;

   // queue status seen by the pipeline control
   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
   } queue_status_type;

endpackage

FILE: rtl/pth_store.sv
// low-pass frame store: one write port, one read port, registered read data
module pth_store (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [pth_pkg::ADDR_BITS-1:0]        wr_addr,
   input  logic signed [pth_pkg::STORE_BITS-1:0] wr_data,
   input  logic                                 rd_en,
   input  logic [pth_pkg::ADDR_BITS-1:0]        rd_addr,
   output logic signed [pth_pkg::STORE_BITS-1:0] rd_data
);

   logic signed [pth_pkg::STORE_BITS-1:0] mem [pth_pkg::MAX_PIXELS];
   logic signed [pth_pkg::STORE_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pth_out_queue.sv
// three-entry result queue between the filter stage and the rsp channel
`include "assert_macros.svh"
module pth_out_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pth_pkg::rsp_item_type      push_item,
   output pth_pkg::queue_status_type  status,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pth_pkg::rsp_item_type      rsp_item
);

   pth_pkg::rsp_item_type           entries_ff [pth_pkg::QUEUE_DEPTH];
   logic [pth_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pth_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pth_pkg::QCNT_BITS-1:0]   count_ff, count_in;
   logic                            pop;

   localparam logic [pth_pkg::QPTR_BITS-1:0] LAST_PTR =
      pth_pkg::QPTR_BITS'(pth_pkg::QUEUE_DEPTH - 1);
   localparam logic [pth_pkg::QCNT_BITS-1:0] FULL_COUNT =
      pth_pkg::QCNT_BITS'(pth_pkg::QUEUE_DEPTH);

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_item  = entries_ff[rd_ptr_ff];

   assign status.count = count_ff;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   // the upstream credit check must never let the queue overflow
   `PTH_ASSERT(a_no_overflow, clock, reset, push |-> (count_ff != FULL_COUNT) || pop, "result queue overflow")
   // a stalled result holds still
   `PTH_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)), "stalled result changed")
   // occupancy stays within the queue depth
   `PTH_ASSERT(a_count_range, clock, reset, count_ff <= FULL_COUNT, "result queue count out of range")

endmodule

FILE: rtl/pixel_temporal_highpass.sv
// top level of the per-pixel temporal iir high-pass filter
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_pixel
//   rsp      out        rsp_valid/rsp_stall  rsp_highpass, rsp_frame_end
//   csr      in         csr_write            csr_index, csr_wdata
//
// one pixel per clock sustained while req_stall is low; the store
// read-modify-write loop has a forward path when back-to-back pixels
// hit one entry. a taken pixel is registered into the filter stage with
// its store read, then its result is pushed into the result queue, whose
// registered count raises rsp_valid. a fill count marks never-written
// entries as zero after reset. a three-entry result queue absorbs rsp stalls;
// req_stall rises when it and the filter stage together hold three results.
`include "assert_macros.svh"
module pixel_temporal_highpass (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pth_pkg::PIXEL_BITS-1:0]  req_pixel,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pth_pkg::HP_BITS-1:0]     rsp_highpass,
   output logic                                   rsp_frame_end,
   input  logic                                   csr_write,
   input  logic [pth_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [pth_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam logic [pth_pkg::FRAME_BITS-1:0] MAX_FRAME =
      pth_pkg::FRAME_BITS'(pth_pkg::MAX_PIXELS);
   localparam logic [pth_pkg::FILL_BITS-1:0] FILL_FULL =
      pth_pkg::FILL_BITS'(pth_pkg::MAX_PIXELS);
   localparam logic [pth_pkg::OCC_BITS-1:0] OCC_LIMIT =
      pth_pkg::OCC_BITS'(pth_pkg::QUEUE_DEPTH);

   // configuration registers
   logic [pth_pkg::FRAME_BITS-1:0] frame_pixels_ff;
   logic [pth_pkg::SHIFT_BITS-1:0] shift_amount_ff;

   // issue side
   logic [pth_pkg::ADDR_BITS-1:0]  pos_ff, pos_in;
   logic [pth_pkg::FILL_BITS-1:0]  fill_ff, fill_in;
   logic [pth_pkg::FRAME_BITS-1:0] frame_size;
   logic                           accept;
   logic                           issue_last;
   logic                           issue_hit;
   logic                           issue_fresh;

   // filter stage
   logic                                    s1_valid_ff;
   logic signed [pth_pkg::PIXEL_BITS-1:0]   s1_pixel_ff;
   logic [pth_pkg::ADDR_BITS-1:0]           s1_addr_ff;
   logic                                    s1_last_ff;
   logic                                    s1_hit_ff;
   logic                                    s1_fresh_ff;
   logic signed [pth_pkg::STORE_BITS-1:0]   s1_fwd_ff;

   logic signed [pth_pkg::STORE_BITS-1:0]   rd_data;
   logic signed [pth_pkg::STORE_BITS-1:0]   lp_old;
   logic signed [pth_pkg::STORE_BITS-1:0]   pix_scaled;
   logic signed [pth_pkg::STORE_BITS-1:0]   diff_raw;
   logic signed [pth_pkg::STORE_BITS-1:0]   diff_shifted;
   logic signed [pth_pkg::STORE_BITS-1:0]   lp_new;
   logic signed [pth_pkg::PIXEL_BITS-1:0]   lp_int;

   pth_pkg::rsp_item_type     result_item;
   pth_pkg::rsp_item_type     rsp_item;
   pth_pkg::queue_status_type queue_status;
   logic [pth_pkg::OCC_BITS-1:0] occupancy;

   // configuration writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff <= pth_pkg::FRAME_PIXELS_RESET;
         shift_amount_ff <= pth_pkg::SHIFT_AMOUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            pth_pkg::CSR_FRAME_PIXELS: frame_pixels_ff <= csr_wdata[pth_pkg::FRAME_BITS-1:0];
            pth_pkg::CSR_SHIFT_AMOUNT: shift_amount_ff <= csr_wdata[pth_pkg::SHIFT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // credit check against the filter stage plus queue
   assign occupancy = pth_pkg::OCC_BITS'(s1_valid_ff) +
                      pth_pkg::OCC_BITS'(queue_status.count);
   assign req_stall = (occupancy >= OCC_LIMIT);
   assign accept    = req_valid && !req_stall;

   // frame size, zero or oversize means a full store
   assign frame_size = (frame_pixels_ff == '0 || frame_pixels_ff > MAX_FRAME) ?
                       MAX_FRAME : frame_pixels_ff;
   assign issue_last = ({1'b0, pos_ff} >= frame_size - 1'b1);

   // same entry written this cycle by the filter stage
   assign issue_hit   = s1_valid_ff && (s1_addr_ff == pos_ff);
   // entry never written since reset reads as zero
   assign issue_fresh = ({1'b0, pos_ff} >= fill_ff);

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = issue_last ? '0 : pos_ff + 1'b1;
      end
   end

   // fill count: entries are written in order from zero, so the written set
   // is always a prefix of the store
   always_comb begin
      fill_in = fill_ff;
      if (s1_valid_ff && ({1'b0, s1_addr_ff} == fill_ff) && (fill_ff != FILL_FULL)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         fill_ff     <= fill_in;
         s1_valid_ff <= accept;
      end
   end

   // filter stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_addr_ff  <= pos_ff;
         s1_last_ff  <= issue_last;
         s1_hit_ff   <= issue_hit;
         s1_fresh_ff <= issue_fresh;
         s1_fwd_ff   <= lp_new;
      end
   end

   pth_store u_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (lp_new),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   // low-pass update and high-pass result
   always_comb begin
      if (s1_hit_ff) begin
         lp_old = s1_fwd_ff;
      end else if (s1_fresh_ff) begin
         lp_old = '0;
      end else begin
         lp_old = rd_data;
      end
      pix_scaled   = {s1_pixel_ff, {pth_pkg::FRAC_BITS{1'b0}}};
      diff_raw     = pix_scaled - lp_old;
      diff_shifted = diff_raw >>> shift_amount_ff;
      lp_new       = lp_old + diff_shifted;
      lp_int       = lp_new[pth_pkg::STORE_BITS-1:pth_pkg::FRAC_BITS];
      result_item.highpass  = {s1_pixel_ff[pth_pkg::PIXEL_BITS-1], s1_pixel_ff} -
                              {lp_int[pth_pkg::PIXEL_BITS-1], lp_int};
      result_item.frame_end = s1_last_ff;
   end

   pth_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_item (result_item),
      .status    (queue_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_highpass  = rsp_item.highpass;
   assign rsp_frame_end = rsp_item.frame_end;

   // a forwarded read only follows a write to the same entry in the cycle before
   `PTH_ASSERT(a_fwd_source, clock, reset, (s1_valid_ff && s1_hit_ff) |-> ($past(s1_valid_ff) && $past(s1_addr_ff) == s1_addr_ff), "forward without matching write")
   // the fill count never shrinks between resets
   `PTH_ASSERT(a_fill_monotonic, clock, reset, 1'b1 |=> (fill_ff >= $past(fill_ff)), "fill count went down")
   // an entry the filter stage reads unforwarded and marked fresh sits at the fill edge
   `PTH_ASSERT(a_fresh_consistent, clock, reset, (s1_valid_ff && s1_fresh_ff && !s1_hit_ff) |-> ({1'b0, s1_addr_ff} == fill_ff), "fresh entry not at fill edge")

endmodule

FILE: tb/pth_checker.sv
// checker for the temporal high-pass filter: predicts each result and compares
module pth_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [pth_pkg::PIXEL_BITS-1:0] req_pixel,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [pth_pkg::HP_BITS-1:0]    rsp_highpass,
   input  logic                                  rsp_frame_end,
   input  logic                                  csr_write,
   input  logic [pth_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pth_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output int                                    fail_count,
   output int                                    pending_count
);

   // predicted filter state and register copies
   logic signed [pth_pkg::STORE_BITS-1:0] lowpass_mem [pth_pkg::MAX_PIXELS];
   int                                    position;
   logic [pth_pkg::FRAME_BITS-1:0]        frame_cfg;
   logic [pth_pkg::SHIFT_BITS-1:0]        shift_cfg;

   // results waiting for their transaction on the rsp channel
   pth_pkg::rsp_item_type                 result_q [$];
   int                                    mismatches = 0;

   // one filter update for the pixel at the current position
   task automatic filter_pixel(input logic signed [pth_pkg::PIXEL_BITS-1:0] pix,
                               output pth_pkg::rsp_item_type res);
      int                                    size;
      int                                    pix_i;
      int                                    lp_i;
      int                                    wide;
      int                                    hp_i;
      logic signed [pth_pkg::STORE_BITS-1:0] lp;
      logic signed [pth_pkg::STORE_BITS-1:0] diff;
      logic signed [pth_pkg::STORE_BITS-1:0] newlp;
      size = (frame_cfg == '0 || int'(frame_cfg) > pth_pkg::MAX_PIXELS) ?
             pth_pkg::MAX_PIXELS : int'(frame_cfg);
      lp = lowpass_mem[position];
      pix_i = int'(pix);
      lp_i = int'(lp);
      wide = pix_i * 16 - lp_i;
      diff = wide[pth_pkg::STORE_BITS-1:0];
      diff = diff >>> shift_cfg;
      newlp = lp + diff;
      lowpass_mem[position] = newlp;
      hp_i = int'(newlp >>> pth_pkg::FRAC_BITS);
      hp_i = pix_i - hp_i;
      res.highpass = hp_i[pth_pkg::HP_BITS-1:0];
      // a frame shortened below the position ends at once
      res.frame_end = (position >= size - 1);
      position = res.frame_end ? 0 : position + 1;
   endtask

   // watch all three ports at each rising clock edge
   always @(posedge clock) begin
      pth_pkg::rsp_item_type predicted;
      pth_pkg::rsp_item_type oldest;
      if (reset) begin
         foreach (lowpass_mem[i]) lowpass_mem[i] = '0;
         position = 0;
         frame_cfg = pth_pkg::FRAME_PIXELS_RESET;
         shift_cfg = pth_pkg::SHIFT_AMOUNT_RESET;
         result_q.delete();
      end else begin
         // register writes, spare indexes ignored
         if (csr_write) begin
            case (csr_index)
               pth_pkg::CSR_FRAME_PIXELS: frame_cfg = csr_wdata[pth_pkg::FRAME_BITS-1:0];
               pth_pkg::CSR_SHIFT_AMOUNT: shift_cfg = csr_wdata[pth_pkg::SHIFT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            filter_pixel(req_pixel, predicted);
            result_q.push_back(predicted);
         end
         // compare each rsp transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               $error("unexpected result: highpass %0d frame_end %0b",
                      rsp_highpass, rsp_frame_end);
               mismatches++;
            end else begin
               oldest = result_q.pop_front();
               if (rsp_highpass !== oldest.highpass) begin
                  $error("highpass: expected %0d, got %0d", oldest.highpass, rsp_highpass);
                  mismatches++;
               end
               if (rsp_frame_end !== oldest.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", oldest.frame_end,
                         rsp_frame_end);
                  mismatches++;
               end
            end
         end
      end
      pending_count <= result_q.size();
      fail_count <= mismatches;
   end

endmodule

FILE: tb/pixel_temporal_highpass_tb.sv
// testbench top for the temporal high-pass filter: stimulus, idling and verdict
module pixel_temporal_highpass_tb;

   localparam logic [pth_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [pth_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic signed [pth_pkg::PIXEL_BITS-1:0] PIX_MIN = 12'sh800;
   localparam logic signed [pth_pkg::PIXEL_BITS-1:0] PIX_MAX = 12'sh7FF;
   localparam int RANDOM_UNTIL = 925;
   localparam int DRAIN_CYCLES = 8;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_type;
   typedef enum {CONTENT_RANDOM, CONTENT_EXTREME, CONTENT_STEADY, CONTENT_NOISY} content_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic signed [pth_pkg::PIXEL_BITS-1:0] req_pixel = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [pth_pkg::HP_BITS-1:0]    rsp_highpass;
   logic                                  rsp_frame_end;
   logic                                  csr_write = 1'b0;
   logic [pth_pkg::CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [pth_pkg::CSR_DATA_BITS-1:0]     csr_wdata = '0;
   int                                    fail_count;
   int                                    pending_count;

   int                                    burst_left = 0;
   int                                    pixels_sent = 0;
   logic [pth_pkg::FRAME_BITS-1:0]        frame_now = pth_pkg::FRAME_PIXELS_RESET;
   stall_mode_type                        stall_mode = STALL_NONE;
   int                                    stall_run = 0;

   pixel_temporal_highpass dut (.*);
   pth_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // rsp side stalls in stretches of differing density
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_run = int'($urandom_range(10, 150));
      end else begin
         stall_run = stall_run - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) != 0);
         default:     rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // one req transaction, then a random gap when the burst runs out
   task automatic send_pixel(input logic signed [pth_pkg::PIXEL_BITS-1:0] px);
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(30, 120))
                                                  : int'($urandom_range(0, 12));
      end
   endtask

   // stop sending and let every pending result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [pth_pkg::CSR_INDEX_BITS-1:0] idx,
                          input logic [pth_pkg::CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (idx == pth_pkg::CSR_FRAME_PIXELS) frame_now = data[pth_pkg::FRAME_BITS-1:0];
   endtask

   // shift word may carry junk above the register width
   task automatic set_filter(input logic [pth_pkg::CSR_DATA_BITS-1:0] frame,
                             input logic [pth_pkg::CSR_DATA_BITS-1:0] shift_word);
      wait_idle();
      csr_put(pth_pkg::CSR_FRAME_PIXELS, frame);
      csr_put(pth_pkg::CSR_SHIFT_AMOUNT, shift_word);
   endtask

   function automatic logic signed [pth_pkg::PIXEL_BITS-1:0] pick_pixel(
         content_type how, logic signed [pth_pkg::PIXEL_BITS-1:0] level);
      logic signed [pth_pkg::PIXEL_BITS-1:0] noise;
      noise = pth_pkg::PIXEL_BITS'($urandom_range(0, 15));
      noise = noise - 12'sd8;
      case (how)
         CONTENT_EXTREME: begin
            case ($urandom_range(0, 3))
               0: return PIX_MIN;
               1: return PIX_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         CONTENT_STEADY: return level;
         CONTENT_NOISY:  return level + noise;
         default:        return pth_pkg::PIXEL_BITS'($urandom);
      endcase
   endfunction

   // new settings, then mostly whole frames of one content style
   task automatic run_random_phase();
      logic [pth_pkg::CSR_DATA_BITS-1:0]     frame;
      logic [pth_pkg::CSR_DATA_BITS-1:0]     shift_word;
      int                                    eff_size;
      int                                    count;
      content_type                           how;
      logic signed [pth_pkg::PIXEL_BITS-1:0] level;
      case ($urandom_range(0, 11))
         0: frame = 11'd1;
         1: frame = '0;
         2: frame = pth_pkg::CSR_DATA_BITS'($urandom_range(pth_pkg::MAX_PIXELS + 1, 2047));
         3: frame = pth_pkg::CSR_DATA_BITS'($urandom_range(65, pth_pkg::MAX_PIXELS));
         4: frame = pth_pkg::CSR_DATA_BITS'(pth_pkg::MAX_PIXELS);
         default: frame = pth_pkg::CSR_DATA_BITS'($urandom_range(2, 16));
      endcase
      shift_word = pth_pkg::CSR_DATA_BITS'($urandom);
      case ($urandom_range(0, 5))
         0: shift_word[pth_pkg::SHIFT_BITS-1:0] = '0;
         1: shift_word[pth_pkg::SHIFT_BITS-1:0] = '1;
         default: ;
      endcase
      wait_idle();
      case ($urandom_range(0, 5))
         0: csr_put(pth_pkg::CSR_FRAME_PIXELS, frame);
         1: csr_put(pth_pkg::CSR_SHIFT_AMOUNT, shift_word);
         2: begin
            csr_put(($urandom_range(0, 1) != 0) ? CSR_SPARE_LO : CSR_SPARE_HI,
                    pth_pkg::CSR_DATA_BITS'($urandom));
            csr_put(pth_pkg::CSR_FRAME_PIXELS, frame);
            csr_put(pth_pkg::CSR_SHIFT_AMOUNT, shift_word);
         end
         default: begin
            csr_put(pth_pkg::CSR_FRAME_PIXELS, frame);
            csr_put(pth_pkg::CSR_SHIFT_AMOUNT, shift_word);
         end
      endcase
      eff_size = (frame_now == '0 || int'(frame_now) > pth_pkg::MAX_PIXELS) ?
                 pth_pkg::MAX_PIXELS : int'(frame_now);
      if (eff_size > 64 || $urandom_range(0, 4) == 0) count = int'($urandom_range(1, 40));
      else count = eff_size * int'($urandom_range(1, 6));
      how = content_type'($urandom_range(0, 3));
      level = pth_pkg::PIXEL_BITS'($urandom);
      repeat (count) send_pixel(pick_pixel(how, level));
   endtask

   // run-away guard
   initial begin
      #600000;
      $display("FAIL pixel_temporal_highpass");
      $finish;
   end

   initial begin
      logic signed [pth_pkg::PIXEL_BITS-1:0] level;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: extremes at the first few positions
      send_pixel(PIX_MIN);
      send_pixel(PIX_MAX);
      send_pixel(-12'sd1);
      send_pixel(12'sd0);
      send_pixel(12'sd1);

      // spare indexes must not disturb the registers
      wait_idle();
      csr_put(CSR_SPARE_LO, 11'h7FF);
      csr_put(CSR_SPARE_HI, 11'h000);

      // one-pixel frame below the current position, no smoothing, diff wraps
      set_filter(11'd1, 11'h7F0);
      send_pixel(PIX_MAX);
      send_pixel(PIX_MIN);
      send_pixel(PIX_MAX);
      send_pixel(PIX_MIN);
      send_pixel(PIX_MIN);
      send_pixel(PIX_MAX);

      // three-pixel frame, slowest time constant
      set_filter(11'd3, 11'h00F);
      send_pixel(PIX_MIN);
      send_pixel(PIX_MAX);
      send_pixel(PIX_MIN);
      send_pixel(PIX_MAX);
      send_pixel(12'sd1);
      send_pixel(-12'sd1);

      // frame size zero and above the store depth both mean full depth
      set_filter(11'd0, 11'd8);
      send_pixel(PIX_MAX);
      send_pixel(PIX_MIN);
      send_pixel(12'sd100);
      set_filter(11'h7FF, 11'h401);
      send_pixel(-12'sd1);
      send_pixel(12'sd0);
      send_pixel(PIX_MAX);

      while (pixels_sent < RANDOM_UNTIL) run_random_phase();

      // full-depth frame that wraps at least once
      set_filter(pth_pkg::CSR_DATA_BITS'(pth_pkg::MAX_PIXELS),
                 pth_pkg::CSR_DATA_BITS'($urandom));
      level = pth_pkg::PIXEL_BITS'($urandom);
      repeat (pth_pkg::MAX_PIXELS + $urandom_range(8, 32))
         send_pixel(pick_pixel(content_type'($urandom_range(0, 3)), level));

      wait_idle();
      if (fail_count == 0) $display("PASS pixel_temporal_highpass");
      else $display("FAIL pixel_temporal_highpass");
      $finish;
   end

endmodule
